[rtl/pphist_pkg.sv]
// shared constants, types and codes of the per-tube energy histogrammer
`default_nettype none

package pphist_pkg;

   // block sizing
   localparam int NUM_TUBES      = 176;
   localparam int NUM_BINS       = 200;
   localparam int BARS_PER_PLANE = 44;

   // tube ranges: top, bottom, south, north, one counter bank each
   localparam int NUM_BANKS  = 4;
   localparam int BANK_W     = $clog2(NUM_BANKS);
   localparam int SLOTS      = NUM_BINS + 2;
   localparam int BANK_DEPTH = BARS_PER_PLANE * SLOTS;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);
   localparam int BIN_W      = $clog2(SLOTS);
   localparam int LT_W       = $clog2(BARS_PER_PLANE);
   localparam int CMP_W      = $clog2(4 * BARS_PER_PLANE + NUM_TUBES + 64) + 1;

   // field widths
   localparam int OP_W         = 1;
   localparam int POS_W        = 12;
   localparam int BAR_W        = 6;
   localparam int STAT_W       = 2;
   localparam int ENERGY_W     = 16;
   localparam int TUBE_FIELD_W = 8;
   localparam int BIN_FIELD_W  = 8;
   localparam int MASK_W       = 4;
   localparam int COUNT_W      = 31;

   // configuration registers
   localparam int CHW_W      = 8;
   localparam int LOW_W      = 16;
   localparam int BINW_W     = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CHW_W-1:0]  CHW_RESET  = CHW_W'(40);
   localparam logic [LOW_W-1:0]  LOW_RESET  = LOW_W'(0);
   localparam logic [BINW_W-1:0] BINW_RESET = BINW_W'(25);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_HALF_WIDTH = 2'd0,
      CSR_HIST_LOW          = 2'd1,
      CSR_BIN_WIDTH         = 2'd2
   } csr_index_type;

   // request opcodes
   localparam logic OP_FILL = 1'b0;
   localparam logic OP_READ = 1'b1;

   // divider step counter
   localparam int DIV_CNT_W = $clog2(ENERGY_W);

   // request payload
   typedef struct packed {
      logic                        op;
      logic signed [POS_W-1:0]     pos_x_mm;
      logic signed [POS_W-1:0]     pos_y_mm;
      logic [BAR_W-1:0]            horiz_bar;
      logic [BAR_W-1:0]            vert_bar;
      logic [STAT_W-1:0]           horiz_status;
      logic [STAT_W-1:0]           vert_status;
      logic signed [ENERGY_W-1:0]  energy_kev;
      logic [TUBE_FIELD_W-1:0]     read_tube;
      logic [BIN_FIELD_W-1:0]      read_bin;
   } req_word_type;

   // response payload
   typedef struct packed {
      logic [MASK_W-1:0]      tube_mask;
      logic [BIN_FIELD_W-1:0] fill_bin;
      logic [COUNT_W-1:0]     count;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_en;
      logic mem_rd;
      logic mem_upd;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_read;
      logic div_done;
      logic clear_last;
   } sts_type;

endpackage

`default_nettype wire

[rtl/pphist_req_if.sv]
// request channel interface
`default_nettype none

interface pphist_req_if;
   import pphist_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        op;
   logic signed [POS_W-1:0]     pos_x_mm;
   logic signed [POS_W-1:0]     pos_y_mm;
   logic [BAR_W-1:0]            horiz_bar;
   logic [BAR_W-1:0]            vert_bar;
   logic [STAT_W-1:0]           horiz_status;
   logic [STAT_W-1:0]           vert_status;
   logic signed [ENERGY_W-1:0]  energy_kev;
   logic [TUBE_FIELD_W-1:0]     read_tube;
   logic [BIN_FIELD_W-1:0]      read_bin;

   modport source (
      output valid, op, pos_x_mm, pos_y_mm, horiz_bar, vert_bar,
             horiz_status, vert_status, energy_kev, read_tube, read_bin,
      input  ready
   );

   modport sink (
      input  valid, op, pos_x_mm, pos_y_mm, horiz_bar, vert_bar,
             horiz_status, vert_status, energy_kev, read_tube, read_bin,
      output ready
   );

endinterface

`default_nettype wire

[rtl/pphist_rsp_if.sv]
// response channel interface
`default_nettype none

interface pphist_rsp_if;
   import pphist_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MASK_W-1:0]      tube_mask;
   logic [BIN_FIELD_W-1:0] fill_bin;
   logic [COUNT_W-1:0]     count;

   modport source (
      output valid, tube_mask, fill_bin, count,
      input  ready
   );

   modport sink (
      input  valid, tube_mask, fill_bin, count,
      output ready
   );

endinterface

`default_nettype wire

[rtl/per_pmt_energy_histogrammer_core.sv]
// top level of the per-tube energy histogrammer
//
//   channel   direction  handshake         word
//   req_if    in         valid/ready       fill hit or counter read
//   rsp_if    out        valid/ready       tube mask, fill bin, count
//   csr_*     in         write enable      register index and data
//
// A fill result is loaded after acceptance through 16 divider steps, the bin
// register, counter read, counter write and output load, a read result through
// counter read, write slot and output load; the next word is then taken in idle.
// After reset the four counter banks are cleared in parallel, one entry a
// cycle, all BARS_PER_PLANE * (NUM_BINS + 2) entries (8888); no word is taken.
// A waiting result does not block the next word; a second one stalls the block.
`default_nettype none

module per_pmt_energy_histogrammer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pphist_req_if.sink                            req_if,
   pphist_rsp_if.source                          rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [pphist_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pphist_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pphist_pkg::*;

   req_word_type req_word;
   rsp_word_type rsp_word;
   cmd_type      cmd;
   sts_type      sts;
   logic         req_ready;
   logic         rsp_valid;

   // pack request word
   assign req_word.op           = req_if.op;
   assign req_word.pos_x_mm     = req_if.pos_x_mm;
   assign req_word.pos_y_mm     = req_if.pos_y_mm;
   assign req_word.horiz_bar    = req_if.horiz_bar;
   assign req_word.vert_bar     = req_if.vert_bar;
   assign req_word.horiz_status = req_if.horiz_status;
   assign req_word.vert_status  = req_if.vert_status;
   assign req_word.energy_kev   = req_if.energy_kev;
   assign req_word.read_tube    = req_if.read_tube;
   assign req_word.read_bin     = req_if.read_bin;

   pphist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pphist_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .sts       (sts)
   );

   // channel outputs
   assign req_if.ready     = req_ready;
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.tube_mask = rsp_word.tube_mask;
   assign rsp_if.fill_bin  = rsp_word.fill_bin;
   assign rsp_if.count     = rsp_word.count;

endmodule

`default_nettype wire

[rtl/pphist_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module pphist_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

[rtl/pphist_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module pphist_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pphist_pkg::ENERGY_W-1:0] dividend,
   input  wire logic [pphist_pkg::BINW_W-1:0]   divisor,
   output logic                               done,
   output logic      [pphist_pkg::ENERGY_W-1:0] quotient
);
   import pphist_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [BINW_W-1:0]    rem_ff;
   logic [BINW_W-1:0]    rem_in;
   logic [ENERGY_W-1:0]  quo_ff;
   logic [ENERGY_W-1:0]  quo_in;
   logic [BINW_W-1:0]    dvs_ff;
   logic [BINW_W+1:0]    diff;

   // trial subtract of the shifted remainder
   always_comb begin
      diff = {1'b0, rem_ff, quo_ff[ENERGY_W-1]} - {2'b00, dvs_ff};
      if (!diff[BINW_W+1]) begin
         rem_in = diff[BINW_W-1:0];
         quo_in = {quo_ff[ENERGY_W-2:0], 1'b1};
      end else begin
         rem_in = {rem_ff[BINW_W-2:0], quo_ff[ENERGY_W-1]};
         quo_in = {quo_ff[ENERGY_W-2:0], 1'b0};
      end
   end

   // iteration control and operand registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(ENERGY_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/pphist_ctrl.sv]
// sequencing controller of the histogrammer
`default_nettype none

module pphist_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire pphist_pkg::sts_type sts,
   output pphist_pkg::cmd_type      cmd
);
   import pphist_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_read ? ST_READ : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.mem_upd = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/pphist_dp.sv]
// datapath: config registers, tube mapping, bin divider, counter banks
`default_nettype none

module pphist_dp (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [pphist_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pphist_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire pphist_pkg::req_word_type          req_word,
   output pphist_pkg::rsp_word_type               rsp_word,
   input  wire pphist_pkg::cmd_type               cmd,
   output pphist_pkg::sts_type                    sts
);
   import pphist_pkg::*;

   // configuration registers
   logic [CHW_W-1:0]  chw_ff;
   logic [LOW_W-1:0]  low_ff;
   logic [BINW_W-1:0] binw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chw_ff  <= CHW_RESET;
         low_ff  <= LOW_RESET;
         binw_ff <= BINW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_HALF_WIDTH: chw_ff  <= csr_wdata[CHW_W-1:0];
            CSR_HIST_LOW:          low_ff  <= csr_wdata[LOW_W-1:0];
            CSR_BIN_WIDTH:         binw_ff <= csr_wdata[BINW_W-1:0];
            default: ;
         endcase
      end
   end

   // hit to tube mapping
   logic [POS_W-1:0]    ax;
   logic [POS_W-1:0]    ay;
   logic                xc;
   logic                yc;
   logic [CMP_W-1:0]    hb;
   logic [CMP_W-1:0]    vb;
   logic                hvalid;
   logic                vvalid;
   logic                hsingle;
   logic                vsingle;
   logic                h_en;
   logic                v_en;
   logic [MASK_W-1:0]   mask_c;
   logic [LT_W-1:0]     hlt_c;
   logic [LT_W-1:0]     vlt_c;

   always_comb begin
      ax = req_word.pos_x_mm[POS_W-1] ? -req_word.pos_x_mm : req_word.pos_x_mm;
      ay = req_word.pos_y_mm[POS_W-1] ? -req_word.pos_y_mm : req_word.pos_y_mm;
      xc = ax < POS_W'(chw_ff);
      yc = ay < POS_W'(chw_ff);
      hb = CMP_W'(req_word.horiz_bar);
      vb = CMP_W'(req_word.vert_bar);
      hvalid  = (hb != '0) && (hb <= CMP_W'(BARS_PER_PLANE));
      vvalid  = (vb != '0) && (vb <= CMP_W'(BARS_PER_PLANE));
      hsingle = (hb == CMP_W'(BARS_PER_PLANE / 2)) || (hb == CMP_W'(BARS_PER_PLANE / 2 + 1));
      vsingle = (vb == CMP_W'(BARS_PER_PLANE / 2)) || (vb == CMP_W'(BARS_PER_PLANE / 2 + 1));
      h_en = hvalid && (xc || (yc && hsingle));
      v_en = vvalid && (yc || (xc && vsingle));
      // north in the fourth range, south third, top first, bottom second
      mask_c[0] = h_en && req_word.horiz_status[0]
                  && (hb - 1'b1 + CMP_W'(3 * BARS_PER_PLANE) < CMP_W'(NUM_TUBES));
      mask_c[1] = h_en && req_word.horiz_status[1]
                  && (hb - 1'b1 + CMP_W'(2 * BARS_PER_PLANE) < CMP_W'(NUM_TUBES));
      mask_c[2] = v_en && req_word.vert_status[0]
                  && (vb - 1'b1 < CMP_W'(NUM_TUBES));
      mask_c[3] = v_en && req_word.vert_status[1]
                  && (vb - 1'b1 + CMP_W'(BARS_PER_PLANE) < CMP_W'(NUM_TUBES));
      hlt_c = hvalid ? LT_W'(hb - 1'b1) : '0;
      vlt_c = vvalid ? LT_W'(vb - 1'b1) : '0;
   end

   // read address split into bank and tube within the bank
   logic [CMP_W-1:0]  rt;
   logic [BANK_W-1:0] rbank_c;
   logic [CMP_W-1:0]  rbase;
   logic [LT_W-1:0]   rlt_c;
   logic              rd_ok_c;

   always_comb begin
      rt = CMP_W'(req_word.read_tube);
      if (rt < CMP_W'(BARS_PER_PLANE)) begin
         rbank_c = BANK_W'(0);
         rbase   = '0;
      end else if (rt < CMP_W'(2 * BARS_PER_PLANE)) begin
         rbank_c = BANK_W'(1);
         rbase   = CMP_W'(BARS_PER_PLANE);
      end else if (rt < CMP_W'(3 * BARS_PER_PLANE)) begin
         rbank_c = BANK_W'(2);
         rbase   = CMP_W'(2 * BARS_PER_PLANE);
      end else begin
         rbank_c = BANK_W'(3);
         rbase   = CMP_W'(3 * BARS_PER_PLANE);
      end
      rd_ok_c = (rt < CMP_W'(NUM_TUBES)) && (rt < CMP_W'(NUM_BANKS * BARS_PER_PLANE))
                && (CMP_W'(req_word.read_bin) < CMP_W'(SLOTS));
      rlt_c = rd_ok_c ? LT_W'(rt - rbase) : '0;
   end

   // energy offset and divider
   logic [ENERGY_W:0]   diff_c;
   logic [BINW_W-1:0]   divisor_c;
   logic                div_done;
   logic [ENERGY_W-1:0] quo;
   logic [BIN_W-1:0]    bin_c;

   assign diff_c    = {req_word.energy_kev[ENERGY_W-1], req_word.energy_kev}
                    - {low_ff[LOW_W-1], low_ff};
   assign divisor_c = (binw_ff == '0) ? BINW_W'(1) : binw_ff;

   pphist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.capture && (req_word.op == OP_FILL)),
      .dividend (diff_c[ENERGY_W-1:0]),
      .divisor  (divisor_c),
      .done     (div_done),
      .quotient (quo)
   );

   // item registers
   logic              is_read_ff;
   logic              neg_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [LT_W-1:0]   hlt_ff;
   logic [LT_W-1:0]   vlt_ff;
   logic [BANK_W-1:0] rbank_ff;
   logic              rd_ok_ff;
   logic [BIN_W-1:0]  bin_ff;

   // bin select: underflow, regular, overflow
   always_comb begin
      if (neg_ff) begin
         bin_c = '0;
      end else if (quo >= ENERGY_W'(NUM_BINS)) begin
         bin_c = BIN_W'(NUM_BINS + 1);
      end else begin
         bin_c = BIN_W'(quo) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_read_ff <= (req_word.op == OP_READ);
         neg_ff     <= diff_c[ENERGY_W];
         rbank_ff   <= rbank_c;
         rd_ok_ff   <= rd_ok_c;
         if (req_word.op == OP_READ) begin
            mask_ff <= '0;
            hlt_ff  <= rlt_c;
            vlt_ff  <= rlt_c;
            bin_ff  <= rd_ok_c ? BIN_W'(req_word.read_bin) : '0;
         end else begin
            mask_ff <= mask_c;
            hlt_ff  <= hlt_c;
            vlt_ff  <= vlt_c;
         end
      end else if (div_done) begin
         bin_ff <= bin_c;
      end
   end

   // clear sweep counter
   logic [ADDR_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // counter banks
   logic [ADDR_W-1:0]  addr   [NUM_BANKS];
   logic [COUNT_W-1:0] rdata  [NUM_BANKS];
   logic [COUNT_W-1:0] incr   [NUM_BANKS];
   logic [NUM_BANKS-1:0] bank_we;

   // bank order top, bottom, south, north against mask bits
   assign bank_we[0] = mask_ff[2];
   assign bank_we[1] = mask_ff[3];
   assign bank_we[2] = mask_ff[1];
   assign bank_we[3] = mask_ff[0];

   for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
      logic [LT_W-1:0] lt;

      assign lt      = (k < 2) ? vlt_ff : hlt_ff;
      assign addr[k] = ADDR_W'(ADDR_W'(lt) * ADDR_W'(SLOTS)) + ADDR_W'(bin_ff);
      assign incr[k] = (rdata[k] == '1) ? rdata[k] : rdata[k] + 1'b1;

      pphist_ram #(
         .WIDTH (COUNT_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (cmd.clear_en || (cmd.mem_upd && !is_read_ff && bank_we[k])),
         .waddr (cmd.clear_en ? clr_ff : addr[k]),
         .wdata (cmd.clear_en ? '0 : incr[k]),
         .re    (cmd.mem_rd),
         .raddr (addr[k]),
         .rdata (rdata[k])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (is_read_ff) begin
            rsp_word.tube_mask <= '0;
            rsp_word.fill_bin  <= '0;
            rsp_word.count     <= rd_ok_ff ? rdata[rbank_ff] : '0;
         end else begin
            rsp_word.tube_mask <= mask_ff;
            rsp_word.fill_bin  <= BIN_FIELD_W'(bin_ff);
            rsp_word.count     <= '0;
         end
      end
   end

   assign sts.req_read   = (req_word.op == OP_READ);
   assign sts.div_done   = div_done;
   assign sts.clear_last = (clr_ff == ADDR_W'(BANK_DEPTH - 1));

endmodule

`default_nettype wire

[tb/sv/per_pmt_energy_histogrammer_core_test.sv]
// self-checking testbench for the per-tube energy histogrammer core
`default_nettype none

module per_pmt_energy_histogrammer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pphist_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int LONG_HOLD      = 250;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_WORDS    = 190;
   localparam int NUM_PHASES     = 8;
   localparam int MAX_REPORTS    = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pphist_req_if req_ch ();
   pphist_rsp_if rsp_ch ();

   // stimulus side drives the channel from these
   req_word_type drive_word = '0;
   logic offer_valid = 1'b0;
   logic sink_ready = 1'b0;

   assign req_ch.valid = offer_valid;
   assign {req_ch.op, req_ch.pos_x_mm, req_ch.pos_y_mm, req_ch.horiz_bar, req_ch.vert_bar,
           req_ch.horiz_status, req_ch.vert_status, req_ch.energy_kev, req_ch.read_tube,
           req_ch.read_bin} = drive_word;
   assign rsp_ch.ready = sink_ready;

   per_pmt_energy_histogrammer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers and the counter banks
   logic [CHW_W-1:0]         cfg_center = CHW_RESET;
   logic signed [LOW_W-1:0]  cfg_low    = LOW_RESET;
   logic [BINW_W-1:0]        cfg_width  = BINW_RESET;
   logic [COUNT_W-1:0]       tube_bins [NUM_TUBES * SLOTS];

   req_word_type req_backlog [$];
   rsp_word_type predicted_rsp [$];

   int words_queued = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int src_gap_max  = 0;
   int snk_gap_max  = 0;
   int src_wait     = 0;
   int snk_wait     = 0;
   int holds_asked  = 0;
   int holds_done   = 0;
   int quiet_cycles = 0;
   logic req_hs = 1'b0;
   logic rsp_hs = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // energy to bin slot under the current register values
   function automatic int energy_slot(int energy);
      int d;
      int w;
      d = energy - int'(cfg_low);
      w = (cfg_width == '0) ? 1 : int'(cfg_width);
      if (d < 0) return 0;
      if (d / w >= NUM_BINS) return NUM_BINS + 1;
      return d / w + 1;
   endfunction

   // saturating increment, false when the tube lies outside the banks
   function automatic bit bump_counter(int tube, int slot);
      if (tube >= NUM_TUBES) return 1'b0;
      if (tube_bins[tube * SLOTS + slot] != COUNT_MAX)
         tube_bins[tube * SLOTS + slot] = tube_bins[tube * SLOTS + slot] + 1'b1;
      return 1'b1;
   endfunction

   // response a word produces, updating the counters on a fill
   function automatic rsp_word_type histogram_response(req_word_type w);
      rsp_word_type r;
      int x;
      int y;
      int hb;
      int vb;
      int slot;
      bit xc;
      bit yc;
      bit hsingle;
      bit vsingle;
      r = '0;
      if (w.op == OP_READ) begin
         if (int'(w.read_tube) < NUM_TUBES && int'(w.read_bin) < SLOTS)
            r.count = tube_bins[int'(w.read_tube) * SLOTS + int'(w.read_bin)];
         return r;
      end
      x = w.pos_x_mm;
      y = w.pos_y_mm;
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      xc = x < int'(cfg_center);
      yc = y < int'(cfg_center);
      hb = w.horiz_bar;
      vb = w.vert_bar;
      hsingle = hb == BARS_PER_PLANE / 2 || hb == BARS_PER_PLANE / 2 + 1;
      vsingle = vb == BARS_PER_PLANE / 2 || vb == BARS_PER_PLANE / 2 + 1;
      slot = energy_slot(w.energy_kev);
      r.fill_bin = BIN_FIELD_W'(slot);
      // horizontal plane: north and south ends
      if (hb >= 1 && hb <= BARS_PER_PLANE && (xc || (yc && hsingle))) begin
         r.tube_mask[0] = w.horiz_status[0] && bump_counter(hb - 1 + 3 * BARS_PER_PLANE, slot);
         r.tube_mask[1] = w.horiz_status[1] && bump_counter(hb - 1 + 2 * BARS_PER_PLANE, slot);
      end
      // vertical plane: top and bottom ends
      if (vb >= 1 && vb <= BARS_PER_PLANE && (yc || (xc && vsingle))) begin
         r.tube_mask[2] = w.vert_status[0] && bump_counter(vb - 1, slot);
         r.tube_mask[3] = w.vert_status[1] && bump_counter(vb - 1 + BARS_PER_PLANE, slot);
      end
      return r;
   endfunction

   // word builders, fields a word does not use are left random
   function automatic req_word_type noise_word();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type make_hit(int x, int y, int hb, int vb, int hs, int vs,
                                             int energy);
      req_word_type w;
      w = noise_word();
      w.op           = OP_FILL;
      w.pos_x_mm     = POS_W'(x);
      w.pos_y_mm     = POS_W'(y);
      w.horiz_bar    = BAR_W'(hb);
      w.vert_bar     = BAR_W'(vb);
      w.horiz_status = STAT_W'(hs);
      w.vert_status  = STAT_W'(vs);
      w.energy_kev   = ENERGY_W'(energy);
      return w;
   endfunction

   function automatic req_word_type make_read(int tube, int slot);
      req_word_type w;
      w = noise_word();
      w.op        = OP_READ;
      w.read_tube = TUBE_FIELD_W'(tube);
      w.read_bin  = BIN_FIELD_W'(slot);
      return w;
   endfunction

   function automatic void offer(req_word_type w);
      req_backlog.push_back(w);
      words_queued++;
   endfunction

   // mostly near the centre lines, sometimes anywhere
   function automatic int pick_pos();
      int span;
      span = int'(cfg_center) + 8;
      if ($urandom_range(0, 9) < 3) return int'($urandom_range(0, 4095)) - 2048;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // valid bar, single-ended ones favored
   function automatic int pick_bar();
      if ($urandom_range(0, 3) == 0) return BARS_PER_PLANE / 2 + int'($urandom_range(0, 1));
      return int'($urandom_range(1, BARS_PER_PLANE));
   endfunction

   // mostly around the histogram range, clamped to the field
   function automatic int pick_energy();
      int w;
      int e;
      if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
      w = (cfg_width == '0) ? 1 : int'(cfg_width);
      e = int'($urandom_range(0, (NUM_BINS + 2) * w));
      e = e + int'(cfg_low) - w;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      return e;
   endfunction

   task automatic write_reg(csr_index_type idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_CENTER_HALF_WIDTH: cfg_center = CHW_W'(value);
         CSR_HIST_LOW:          cfg_low = LOW_W'(value);
         default:               cfg_width = BINW_W'(value);
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (results_seen < words_queued) @(negedge clock);
   endtask

   // request handshake seen at the rising edge
   always @(posedge clock) begin
      req_hs <= !reset && req_ch.valid && req_ch.ready;
   end

   // driver: predict the accepted word, then offer the next after its gap
   always @(negedge clock) begin
      if (!reset) begin
         if (req_hs) begin
            predicted_rsp.push_back(histogram_response(drive_word));
            src_wait = $urandom_range(0, src_gap_max);
         end
         if (req_hs || !offer_valid) begin
            if (src_wait != 0) begin
               src_wait--;
               offer_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               drive_word  <= req_backlog.pop_front();
               offer_valid <= 1'b1;
            end else begin
               offer_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_word_type seen;
      rsp_word_type want;
      rsp_hs <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen = {rsp_ch.tube_mask, rsp_ch.fill_bin, rsp_ch.count};
         results_seen++;
         if (predicted_rsp.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("response %0d with none pending: mask %h bin %0d count %0d",
                        results_seen, seen.tube_mask, seen.fill_bin, seen.count);
            mismatches++;
         end else begin
            want = predicted_rsp.pop_front();
            if (seen.tube_mask !== want.tube_mask || seen.fill_bin !== want.fill_bin ||
                seen.count !== want.count) begin
               if (mismatches < MAX_REPORTS)
                  $display("response %0d: expected mask %h bin %0d count %0d, got mask %h bin %0d count %0d",
                           results_seen, want.tube_mask, want.fill_bin, want.count,
                           seen.tube_mask, seen.fill_bin, seen.count);
               mismatches++;
            end
         end
      end
   end

   // monitor ready: random stall after each word, long hold-off on request
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hs) snk_wait = $urandom_range(0, snk_gap_max);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            snk_wait   = LONG_HOLD;
         end
         if (snk_wait != 0) begin
            snk_wait--;
            sink_ready <= 1'b0;
         end else begin
            sink_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_word_type pool [4];
      req_word_type w;
      int pick;
      int tube;
      int chw;
      int low;
      int width;
      int src_max;
      int snk_max;
      bit squeeze;

      // counters start cleared
      foreach (tube_bins[i]) tube_bins[i] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset register values
      src_gap_max = 17;
      snk_gap_max = 17;
      // all four ends, then the same tubes again
      offer(make_hit(0, 0, 1, 44, 3, 3, 0));
      offer(make_hit(0, 0, 1, 44, 3, 3, 24));
      // central x with a single-ended vertical bar
      offer(make_hit(39, 2047, 10, 22, 3, 3, 25));
      // central y with a single-ended horizontal bar, top bin
      offer(make_hit(-40, -39, 23, 5, 1, 2, 4999));
      // nothing central with underflow at the most negative energy, then central y at the most positive
      offer(make_hit(-2048, -2048, 44, 1, 3, 3, -32768));
      offer(make_hit(2047, 0, 22, 23, 2, 1, 32767));
      // bars out of range, first overflow energy, just below the low edge
      offer(make_hit(0, 0, 0, 63, 3, 3, 5000));
      offer(make_hit(-1, 1, 45, 0, 3, 3, -1));
      // no ends seen
      offer(make_hit(0, 0, 44, 1, 0, 0, 100));
      // far from both centre lines, with single-ended bars and then with bar 1 in both planes
      offer(make_hit(-2048, 2047, 22, 23, 3, 3, 50));
      offer(make_hit(2047, -2048, 1, 1, 3, 3, 0));
      // reads of filled counters, range edges and out-of-range indexes
      offer(make_read(43, 1));
      offer(make_read(87, 1));
      offer(make_read(88, 1));
      offer(make_read(132, 1));
      offer(make_read(21, 2));
      offer(make_read(154, 200));
      offer(make_read(175, 201));
      offer(make_read(176, 0));
      offer(make_read(255, 255));
      offer(make_read(0, 202));
      offer(make_read(0, 0));
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         squeeze = 1'b0;
         case (p)
            0: begin
               chw = 1;   low = -32768; width = 1;    src_max = 17; snk_max = 17;
            end
            1: begin
               chw = 255; low = 32767;  width = 4095; src_max = 0;  snk_max = 0;
               squeeze = 1'b1;
            end
            2: begin
               chw = 60;  low = -500;   width = 10;   src_max = 3;  snk_max = 17;
            end
            3: begin
               // zero width behaves as width one
               chw = 20;  low = 1000;   width = 0;    src_max = 17; snk_max = 3;
            end
            4: begin
               chw = 40;  low = 0;      width = 25;   src_max = 0;  snk_max = 17;
               squeeze = 1'b1;
            end
            default: begin
               chw     = $urandom_range(1, 255);
               low     = int'($urandom_range(0, 4000)) - 2000;
               width   = $urandom_range(1, 300);
               src_max = 17 * $urandom_range(0, 1);
               snk_max = 17 * $urandom_range(0, 1);
            end
         endcase
         write_reg(CSR_CENTER_HALF_WIDTH, chw);
         write_reg(CSR_HIST_LOW, low);
         write_reg(CSR_BIN_WIDTH, width);
         @(posedge clock);
         src_gap_max = src_max;
         snk_gap_max = snk_max;
         if (squeeze) holds_asked++;

         // a few recurring hits so counters climb and reads find them
         foreach (pool[i])
            pool[i] = make_hit(pick_pos(), pick_pos(), pick_bar(), pick_bar(), 3, 3,
                               pick_energy());

         repeat (PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // read a counter one of the recurring hits lands in
               w = pool[$urandom_range(0, 3)];
               case ($urandom_range(0, 3))
                  0:       tube = int'(w.vert_bar) - 1;
                  1:       tube = int'(w.vert_bar) - 1 + BARS_PER_PLANE;
                  2:       tube = int'(w.horiz_bar) - 1 + 2 * BARS_PER_PLANE;
                  default: tube = int'(w.horiz_bar) - 1 + 3 * BARS_PER_PLANE;
               endcase
               offer(make_read(tube, energy_slot(w.energy_kev)));
            end else if (pick < 20) begin
               offer(make_read($urandom_range(0, 255), $urandom_range(0, 255)));
            end else if (pick < 50) begin
               w = pool[$urandom_range(0, 3)];
               if ($urandom_range(0, 3) == 0) w.horiz_status = STAT_W'($urandom_range(0, 3));
               if ($urandom_range(0, 3) == 0) w.vert_status = STAT_W'($urandom_range(0, 3));
               offer(w);
            end else if (pick < 85) begin
               offer(make_hit(pick_pos(), pick_pos(), pick_bar(), pick_bar(),
                              $urandom_range(0, 3), $urandom_range(0, 3), pick_energy()));
            end else begin
               // fully random fill
               w = noise_word();
               w.op = OP_FILL;
               offer(w);
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && predicted_rsp.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

[per_pmt_energy_histogrammer_core.f]
rtl/pphist_pkg.sv
rtl/pphist_req_if.sv
rtl/pphist_rsp_if.sv
rtl/pphist_ram.sv
rtl/pphist_div.sv
rtl/pphist_ctrl.sv
rtl/pphist_dp.sv
rtl/per_pmt_energy_histogrammer_core.sv
tb/sv/per_pmt_energy_histogrammer_core_test.sv
